// File: hdl/snhe_pkg.sv
// ----------------------------------------------------------------------------
// snhe_pkg
// Types and constants shared by the symbol name hash encoder modules.
// ----------------------------------------------------------------------------
package snhe_pkg;

	localparam int CNT_BITS_DEF = 32;

	typedef logic [31:0] word_t;
	typedef logic [4:0][31:0] chain_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_FEED,
		ST_ROUND,
		ST_FOLD,
		ST_EMIT
	} state_t;

	typedef enum logic [2:0] {
		FP_NONE,
		FP_TAIL,
		FP_MARK,
		FP_ZERO,
		FP_LEN,
		FP_DONE
	} feed_t;

	typedef struct packed {
		logic       put_byte;
		logic       put_word;
		logic [7:0] data;
	} blk_ctl_t;

	typedef struct packed {
		logic       init;
		logic       step;
		logic [6:0] rnd;
	} rnd_ctl_t;

	localparam chain_t CHAIN_INIT = {
		32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
	};

	localparam logic [127:0] TAIL_BYTES = 128'h518D64A635DED8C1E6B039B1C3E55230;
	localparam logic [8*64-1:0] ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+-";

	localparam logic [6:0] ROUND_LAST = 7'd79;
	localparam logic [3:0] CHAR_LAST  = 4'd10;
	localparam logic [5:0] BLOCK_LAST = 6'd63;
	localparam logic [5:0] LEN_POS    = 6'd56;
	localparam logic [3:0] TAIL_LAST  = 4'd15;
	localparam logic [3:0] LEN_LAST   = 4'd7;
	localparam logic [7:0] PAD_MARK   = 8'h80;

	localparam word_t K_0 = 32'h5A827999;
	localparam word_t K_1 = 32'h6ED9EBA1;
	localparam word_t K_2 = 32'h8F1BBCDC;
	localparam word_t K_3 = 32'hCA62C1D6;

endpackage

// File: hdl/snhe_round.sv
// ----------------------------------------------------------------------------
// snhe_round
// SHA-1 working variables and the shared round unit, one round per cycle.
// ----------------------------------------------------------------------------
module snhe_round (
	input  logic               clk,
	input  snhe_pkg::rnd_ctl_t ctl,
	input  snhe_pkg::chain_t   chain,
	input  snhe_pkg::word_t    w,
	output snhe_pkg::chain_t   work
);
	import snhe_pkg::*;

	chain_t work_q;
	word_t  a, b, c, d, e, f, k, t;

	assign a = work_q[0];
	assign b = work_q[1];
	assign c = work_q[2];
	assign d = work_q[3];
	assign e = work_q[4];

	always_comb begin
		if (ctl.rnd < 7'd20) begin
			f = (b & c) | (~b & d);
			k = K_0;
		end else if (ctl.rnd < 7'd40) begin
			f = b ^ c ^ d;
			k = K_1;
		end else if (ctl.rnd < 7'd60) begin
			f = (b & c) | (b & d) | (c & d);
			k = K_2;
		end else begin
			f = b ^ c ^ d;
			k = K_3;
		end
		t = {a[26:0], a[31:27]} + f + e + k + w;
	end

	always_ff @(posedge clk) begin
		if (ctl.init) begin
			work_q <= chain;
		end else if (ctl.step) begin
			work_q[0] <= t;
			work_q[1] <= a;
			work_q[2] <= {b[1:0], b[31:2]};
			work_q[3] <= c;
			work_q[4] <= d;
		end
	end

	assign work = work_q;

endmodule

// File: hdl/snhe_block.sv
// ----------------------------------------------------------------------------
// snhe_block
// 64-byte message block buffer. Bytes shift in during loading; during the
// rounds it runs as the 16-word message schedule window.
// ----------------------------------------------------------------------------
module snhe_block (
	input  logic               clk,
	input  snhe_pkg::blk_ctl_t ctl,
	output snhe_pkg::word_t    w0
);
	import snhe_pkg::*;

	logic [511:0] blk_q;
	word_t        w_next;

	assign w0 = blk_q[511:480];

	always_comb begin
		w_next = blk_q[511-32*13 -: 32] ^ blk_q[511-32*8 -: 32] ^
			blk_q[511-32*2 -: 32] ^ blk_q[511:480];
		w_next = {w_next[30:0], w_next[31]};
	end

	always_ff @(posedge clk) begin
		if (ctl.put_byte) begin
			blk_q <= {blk_q[503:0], ctl.data};
		end else if (ctl.put_word) begin
			blk_q <= {blk_q[479:0], w_next};
		end
	end

endmodule

// File: hdl/symbol_name_hash_encoder.sv
// ----------------------------------------------------------------------------
// symbol_name_hash_encoder
// Hashes a symbol name with SHA-1 and encodes part of the digest as an
// eleven-character identifier.
// ----------------------------------------------------------------------------
// The name arrives one byte per beat: a beat is taken on a clock edge with
// start high and busy low, and final_byte marks the last byte of the name.
// Each 64th byte of the hashed stream starts a compression, one SHA-1
// round per cycle in a single shared round unit, then a fold into the
// chaining words; busy is high meanwhile. After the final byte the block
// appends the fixed 16-byte suffix and the SHA-1 padding one byte per
// cycle, pausing while it compresses once or twice more. Eleven characters
// then follow on consecutive cycles, each marked by char_valid for one
// cycle; last_char flags the eleventh. The receiver cannot stall this
// output. Afterwards the block is ready for a new name. Reset puts the
// chaining words to the SHA-1 initial values and clears the byte count;
// busy is low from reset on, so a beat can be taken at the first clock
// edge after reset is released.
// ----------------------------------------------------------------------------
module symbol_name_hash_encoder #(
	parameter int COUNT_BITS = snhe_pkg::CNT_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [7:0] name_byte,
	input  logic       final_byte,
	output logic       char_valid,
	output logic [7:0] symbol_char,
	output logic       last_char
);
	import snhe_pkg::*;

	state_t                state_q, state_d;
	feed_t                 feed_q;
	logic [3:0]            feed_idx_q;
	logic [5:0]            pos_q;
	logic [COUNT_BITS-1:0] total_q;
	logic [6:0]            round_q;
	logic [3:0]            emit_q;
	chain_t                chain_q, chain_sum, work;
	logic [63:0]           v_q, len64;
	logic [7:0]            feed_byte;
	word_t                 w0;
	blk_ctl_t              blk_ctl;
	rnd_ctl_t              rnd_ctl;

	snhe_block u_block (
		.clk (clk),
		.ctl (blk_ctl),
		.w0  (w0)
	);

	snhe_round u_round (
		.clk   (clk),
		.ctl   (rnd_ctl),
		.chain (chain_q),
		.w     (w0),
		.work  (work)
	);

	assign len64 = 64'(total_q) << 3;

	always_comb begin
		case (feed_q)
			FP_TAIL: feed_byte = TAIL_BYTES[{~feed_idx_q, 3'b000} +: 8];
			FP_MARK: feed_byte = PAD_MARK;
			FP_LEN:  feed_byte = len64[{~feed_idx_q[2:0], 3'b000} +: 8];
			default: feed_byte = 8'h00;
		endcase
	end

	always_comb begin
		for (int i = 0; i < 5; i++) begin
			chain_sum[i] = chain_q[i] + work[i];
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (start) begin
					if (pos_q == BLOCK_LAST) begin
						state_d = ST_ROUND;
					end else if (final_byte) begin
						state_d = ST_FEED;
					end
				end
			end
			ST_FEED: begin
				if (pos_q == BLOCK_LAST) begin
					state_d = ST_ROUND;
				end
			end
			ST_ROUND: begin
				if (round_q == ROUND_LAST) begin
					state_d = ST_FOLD;
				end
			end
			ST_FOLD: begin
				if (feed_q == FP_DONE) begin
					state_d = ST_EMIT;
				end else if (feed_q == FP_NONE) begin
					state_d = ST_LOAD;
				end else begin
					state_d = ST_FEED;
				end
			end
			ST_EMIT: begin
				if (emit_q == CHAR_LAST) begin
					state_d = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		busy             = 1'b1;
		char_valid       = 1'b0;
		blk_ctl.put_byte = 1'b0;
		blk_ctl.put_word = 1'b0;
		blk_ctl.data     = feed_byte;
		rnd_ctl.step     = 1'b0;
		rnd_ctl.rnd      = round_q;
		case (state_q)
			ST_LOAD: begin
				busy             = 1'b0;
				blk_ctl.put_byte = start;
				blk_ctl.data     = name_byte;
			end
			ST_FEED: begin
				blk_ctl.put_byte = 1'b1;
			end
			ST_ROUND: begin
				blk_ctl.put_word = 1'b1;
				rnd_ctl.step     = 1'b1;
			end
			ST_EMIT: begin
				char_valid = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
		rnd_ctl.init = blk_ctl.put_byte && (pos_q == BLOCK_LAST);
	end

	assign symbol_char = ALPHABET[{~v_q[63:58], 3'b000} +: 8];
	assign last_char   = (emit_q == CHAR_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			feed_q     <= FP_NONE;
			feed_idx_q <= '0;
			pos_q      <= '0;
			total_q    <= '0;
			round_q    <= '0;
			emit_q     <= '0;
			chain_q    <= CHAIN_INIT;
		end else begin
			state_q <= state_d;
			if (blk_ctl.put_byte) begin
				pos_q <= pos_q + 6'd1;
				if (state_q == ST_LOAD || feed_q == FP_TAIL) begin
					total_q <= total_q + COUNT_BITS'(1);
				end
			end
			if (state_q == ST_LOAD && start && final_byte) begin
				feed_q     <= FP_TAIL;
				feed_idx_q <= '0;
			end
			if (state_q == ST_FEED) begin
				case (feed_q)
					FP_TAIL: begin
						if (feed_idx_q == TAIL_LAST) begin
							feed_q     <= FP_MARK;
							feed_idx_q <= '0;
						end else begin
							feed_idx_q <= feed_idx_q + 4'd1;
						end
					end
					FP_MARK, FP_ZERO: begin
						if (pos_q + 6'd1 == LEN_POS) begin
							feed_q <= FP_LEN;
						end else begin
							feed_q <= FP_ZERO;
						end
					end
					FP_LEN: begin
						if (feed_idx_q == LEN_LAST) begin
							feed_q <= FP_DONE;
						end
						feed_idx_q <= feed_idx_q + 4'd1;
					end
					default: feed_q <= feed_q;
				endcase
			end
			if (state_q == ST_ROUND) begin
				round_q <= (round_q == ROUND_LAST) ? '0 : round_q + 7'd1;
			end
			if (state_q == ST_FOLD) begin
				chain_q <= chain_sum;
			end
			if (state_q == ST_EMIT) begin
				if (emit_q == CHAR_LAST) begin
					emit_q  <= '0;
					chain_q <= CHAIN_INIT;
					total_q <= '0;
					pos_q   <= '0;
					feed_q  <= FP_NONE;
				end else begin
					emit_q <= emit_q + 4'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FOLD) begin
			v_q <= {chain_sum[1][7:0], chain_sum[1][15:8], chain_sum[1][23:16],
				chain_sum[1][31:24], chain_sum[0][7:0], chain_sum[0][15:8],
				chain_sum[0][23:16], chain_sum[0][31:24]};
		end else if (state_q == ST_EMIT) begin
			v_q <= {v_q[57:0], 6'b000000};
		end
	end

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the symbol name hash encoder.
// ----------------------------------------------------------------------------
// Names are sent one byte per beat, with random gaps between beats. The
// first names are chosen by hand: single bytes at both extremes, short
// patterns and a run of zero bytes. The rest are random names. Most are
// short, and a few have lengths that put the padding across a block
// boundary or end the name on one. A SHA-1 model inside the bench predicts
// the eleven identifier characters of each name. Every character strobe
// is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NAME_BYTES   = 270;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int DRAIN_CYCLES = 200;

	localparam logic [127:0] NAME_SUFFIX = 128'h518D64A635DED8C1E6B039B1C3E55230;
	localparam logic [8*64-1:0] CODE_CHARS =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+-";
	localparam logic [31:0] SHA1_H0 = 32'h67452301;
	localparam logic [31:0] SHA1_H1 = 32'hEFCDAB89;
	localparam logic [31:0] SHA1_H2 = 32'h98BADCFE;
	localparam logic [31:0] SHA1_H3 = 32'h10325476;
	localparam logic [31:0] SHA1_H4 = 32'hC3D2E1F0;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic [7:0] gap_after;
	} name_beat_t;

	typedef struct packed {
		logic [7:0] symbol;
		logic       last;
	} id_char_t;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic [7:0] name_byte;
	logic       final_byte;
	logic       char_valid;
	logic [7:0] symbol_char;
	logic       last_char;

	name_beat_t name_beats[$];
	id_char_t   id_chars_due[$];
	name_beat_t drive_beat;
	id_char_t   due_char;
	logic       took;
	int         gap_left;
	int         mismatches;
	int         cycle_count;
	int         bytes_queued;
	int         names_hashed;
	int         chars_checked;

	logic [31:0] hash_chain[5];
	logic [7:0]  hash_block[64];
	logic [31:0] hashed_count;

	symbol_name_hash_encoder DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.name_byte   (name_byte),
		.final_byte  (final_byte),
		.char_valid  (char_valid),
		.symbol_char (symbol_char),
		.last_char   (last_char)
	);

	always #2 clk = ~clk;

	task automatic report(input string msg);
		$display("mismatch: %s", msg);
		mismatches++;
	endtask

	function automatic void hash_restart();
		hash_chain[0] = SHA1_H0;
		hash_chain[1] = SHA1_H1;
		hash_chain[2] = SHA1_H2;
		hash_chain[3] = SHA1_H3;
		hash_chain[4] = SHA1_H4;
		hashed_count = '0;
	endfunction

	function automatic void sha1_compress();
		logic [31:0] w[80];
		logic [31:0] a, b, c, d, e, f, k, t;
		for (int i = 0; i < 16; i++)
			w[i] = {hash_block[4*i], hash_block[4*i+1], hash_block[4*i+2], hash_block[4*i+3]};
		for (int i = 16; i < 80; i++) begin
			t = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
			w[i] = {t[30:0], t[31]};
		end
		a = hash_chain[0];
		b = hash_chain[1];
		c = hash_chain[2];
		d = hash_chain[3];
		e = hash_chain[4];
		for (int i = 0; i < 80; i++) begin
			if (i < 20) begin
				f = (b & c) | (~b & d);
				k = 32'h5A827999;
			end else if (i < 40) begin
				f = b ^ c ^ d;
				k = 32'h6ED9EBA1;
			end else if (i < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = 32'h8F1BBCDC;
			end else begin
				f = b ^ c ^ d;
				k = 32'hCA62C1D6;
			end
			t = {a[26:0], a[31:27]} + f + e + k + w[i];
			e = d;
			d = c;
			c = {b[1:0], b[31:2]};
			b = a;
			a = t;
		end
		hash_chain[0] += a;
		hash_chain[1] += b;
		hash_chain[2] += c;
		hash_chain[3] += d;
		hash_chain[4] += e;
	endfunction

	function automatic void hash_absorb(input logic [7:0] v);
		logic [5:0] pos;
		pos = hashed_count[5:0];
		hash_block[pos] = v;
		hashed_count = hashed_count + 32'd1;
		if (pos == 6'd63)
			sha1_compress();
	endfunction

	function automatic void hash_pad(inout logic [6:0] pos, input logic [7:0] v);
		hash_block[pos[5:0]] = v;
		pos = pos + 7'd1;
		if (pos == 7'd64) begin
			sha1_compress();
			pos = '0;
		end
	endfunction

	function automatic logic [7:0] code_char(input int idx);
		return CODE_CHARS[8*(63 - idx) +: 8];
	endfunction

	function automatic void predict_beat(input logic [7:0] data, input logic last);
		logic [6:0]  pos;
		logic [63:0] bit_len;
		logic [63:0] v;
		id_char_t    c;
		hash_absorb(data);
		if (last) begin
			for (int i = 0; i < 16; i++)
				hash_absorb(NAME_SUFFIX[8*(15-i) +: 8]);
			bit_len = {29'd0, hashed_count, 3'd0};
			pos = {1'b0, hashed_count[5:0]};
			hash_pad(pos, 8'h80);
			while (pos != 7'd56)
				hash_pad(pos, 8'h00);
			for (int i = 7; i >= 0; i--)
				hash_pad(pos, bit_len[8*i +: 8]);
			for (int i = 0; i < 4; i++) begin
				v[8*i +: 8] = hash_chain[0][8*(3-i) +: 8];
				v[32+8*i +: 8] = hash_chain[1][8*(3-i) +: 8];
			end
			for (int i = 0; i < 10; i++) begin
				c.symbol = code_char(int'(v[4+6*(9-i) +: 6]));
				c.last = 1'b0;
				id_chars_due.push_back(c);
			end
			c.symbol = code_char(int'({v[3:0], 2'b00}));
			c.last = 1'b1;
			id_chars_due.push_back(c);
			names_hashed++;
			hash_restart();
		end
	endfunction

	function automatic logic [7:0] pick_gap(input bit quiet);
		int r;
		if (quiet)
			return 8'd0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 8'd0;
		if (r < 85)
			return 8'($urandom_range(1, 3));
		if (r < 95)
			return 8'($urandom_range(4, 10));
		return 8'($urandom_range(20, 60));
	endfunction

	task automatic push_byte(input logic [7:0] data, input logic last, input bit quiet);
		name_beat_t nb;
		nb.data = data;
		nb.last = last;
		nb.gap_after = pick_gap(quiet);
		name_beats.push_back(nb);
		bytes_queued++;
	endtask

	task automatic push_random_name(input int len);
		bit quiet;
		quiet = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < len; i++)
			push_byte(8'($urandom_range(0, 255)), i == len - 1, quiet);
	endtask

	always @(negedge clk) begin
		if (arst_n && !(start && !took)) begin
			if (gap_left != 0) begin
				start <= 1'b0;
				name_byte <= 8'($urandom_range(0, 255));
				final_byte <= 1'($urandom_range(0, 1));
				gap_left--;
			end else if (name_beats.size() != 0) begin
				drive_beat = name_beats.pop_front();
				start <= 1'b1;
				name_byte <= drive_beat.data;
				final_byte <= drive_beat.last;
				gap_left = int'(drive_beat.gap_after);
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			took <= 1'b0;
		end else begin
			took <= start && !busy;
			if (start && !busy)
				predict_beat(name_byte, final_byte);
			if (char_valid) begin
				if (id_chars_due.size() == 0) begin
					report($sformatf("unexpected character %h", symbol_char));
				end else begin
					due_char = id_chars_due.pop_front();
					chars_checked++;
					if (symbol_char !== due_char.symbol)
						report($sformatf("symbol_char got %h want %h", symbol_char,
							due_char.symbol));
					if (last_char !== due_char.last)
						report($sformatf("last_char got %b want %b", last_char, due_char.last));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout with %0d characters outstanding", id_chars_due.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		int len;
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		name_byte = 8'h00;
		final_byte = 1'b0;
		took = 1'b0;
		gap_left = 0;
		mismatches = 0;
		cycle_count = 0;
		bytes_queued = 0;
		names_hashed = 0;
		chars_checked = 0;
		hash_restart();

		push_byte(8'h00, 1'b1, 1'b0);
		push_byte(8'hFF, 1'b1, 1'b0);
		push_byte(8'hAA, 1'b0, 1'b1);
		push_byte(8'h55, 1'b1, 1'b1);
		push_byte(8'h61, 1'b0, 1'b0);
		push_byte(8'h62, 1'b0, 1'b0);
		push_byte(8'h63, 1'b1, 1'b0);
		for (int i = 0; i < 17; i++)
			push_byte(8'h00, i == 16, 1'b1);

		while (bytes_queued < NAME_BYTES) begin
			case ($urandom_range(0, 9))
				7, 8: begin
					case ($urandom_range(0, 4))
						0: len = 39;
						1: len = 40;
						2: len = 47;
						3: len = 48;
						default: len = 64;
					endcase
				end
				9: len = $urandom_range(13, 30);
				default: len = $urandom_range(1, 12);
			endcase
			push_random_name(len);
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (name_beats.size() != 0 || start)
			@(posedge clk);
		while (id_chars_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Hashed %0d names from %0d name bytes, checked %0d identifier characters.",
			names_hashed, bytes_queued, chars_checked);
		$display("Lengths ranged from one byte to padding and suffix across block boundaries.");
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
